// File: src/dtph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtph_pkg - shared types for the photon histogrammer
// Item, result, command and configuration types, plus small helpers.
// ----------------------------------------------------------------------------
package dtph_pkg;

    // fixed field widths
    localparam int unsigned TW  = 24;   // event time width
    localparam int unsigned BWW = 16;   // bin width register width
    localparam int unsigned RBW = 10;   // read_bin / bin_hit width
    localparam int unsigned CW  = 32;   // counter width
    localparam int unsigned AW  = 48;   // absolute time width

    typedef enum logic [1:0] {
        ACT_PHOTON = 2'd0,
        ACT_NEXT   = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CMD_NOP   = 2'd0,
        CMD_BIN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_kind_t;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_CYCLE_PERIOD = 3'd0;
    localparam logic [2:0] REG_BIN_WIDTH    = 3'd1;
    localparam logic [2:0] REG_BINS_IN_USE  = 3'd2;
    localparam logic [2:0] REG_DEAD_TIME    = 3'd3;
    localparam logic [2:0] REG_PARALYZABLE  = 3'd4;
    localparam logic [2:0] REG_FIRST_ONLY   = 3'd5;

    typedef struct packed {
        logic [1:0]     action;
        logic [TW-1:0]  event_time;
        logic [RBW-1:0] read_bin;
    } item_t;

    typedef struct packed {
        logic           accepted;
        logic [RBW-1:0] bin_hit;
        logic [CW-1:0]  bin_count;
        logic [CW-1:0]  recorded_cycles;
    } result_t;

    typedef struct packed {
        logic [TW-1:0]  cycle_period;
        logic [BWW-1:0] bin_ticks;
        logic [10:0]    bins_in_use;
        logic [TW-1:0]  blind_ticks;
        logic           paralyzable;
        logic           first_only;
    } cfg_t;

    // classified work handed from front to back
    typedef struct packed {
        cmd_kind_t      kind;
        logic [TW-1:0]  t;
        logic [RBW-1:0] rb;
        logic           inc_hit;
    } cmd_t;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        sat_inc = (v == '1) ? v : v + CW'(1);
    endfunction

endpackage

// File: src/dead_time_photon_histogrammer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dead_time_photon_histogrammer - TCSPC histogrammer with detector dead time
// Bins photon times within each laser cycle into a saturating histogram.
// ----------------------------------------------------------------------------
// Usage:
//   item/item_valid/item_ready take one transfer per item (photon, next cycle,
//   read bin, clear). result/result_valid/result_ready return exactly one
//   result per item, in order. Registers are to be written over the APB port
//   only while the block is idle; the block itself does not enforce this.
//   Sequencing: the front takes each item through intake, calculate and
//   issue states. The back end runs a binned photon through a 24-step
//   restoring divider and, for an in-range bin, a read-modify-write of the
//   histogram RAM, a bin read through a RAM read, and a clear through a sweep
//   of every bin (one bin zeroed per cycle); anything else is answered at
//   once. The back end takes one command at a time; the front keeps taking
//   items while the queue has room. After reset the histogram RAM is swept
//   to zero; item_ready stays low during that pass.
//   A two-entry command queue and the result register let the front keep
//   taking items while a result waits on a stalled receiver.
// ----------------------------------------------------------------------------
module dead_time_photon_histogrammer #(
    parameter int unsigned MAX_BINS  = 1024,
    parameter int unsigned TIME_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  dtph_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output dtph_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import dtph_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic init_busy;
    logic q_push, q_full, q_pop, q_valid;
    cmd_t q_wdata, q_rdata;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[4:2])
                REG_CYCLE_PERIOD: cfg_next.cycle_period = pwdata[TW-1:0];
                REG_BIN_WIDTH:    cfg_next.bin_ticks    = pwdata[BWW-1:0];
                REG_BINS_IN_USE:  cfg_next.bins_in_use  = pwdata[10:0];
                REG_DEAD_TIME:    cfg_next.blind_ticks  = pwdata[TW-1:0];
                REG_PARALYZABLE:  cfg_next.paralyzable  = pwdata[0];
                REG_FIRST_ONLY:   cfg_next.first_only   = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (paddr[4:2])
            REG_CYCLE_PERIOD: prdata = 32'(cfg_reg.cycle_period);
            REG_BIN_WIDTH:    prdata = 32'(cfg_reg.bin_ticks);
            REG_BINS_IN_USE:  prdata = 32'(cfg_reg.bins_in_use);
            REG_DEAD_TIME:    prdata = 32'(cfg_reg.blind_ticks);
            REG_PARALYZABLE:  prdata = 32'(cfg_reg.paralyzable);
            REG_FIRST_ONLY:   prdata = 32'(cfg_reg.first_only);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cycle_period <= TW'(16384);
            cfg_reg.bin_ticks    <= BWW'(16);
            cfg_reg.bins_in_use  <= 11'd1024;
            cfg_reg.blind_ticks  <= '0;
            cfg_reg.paralyzable  <= 1'b0;
            cfg_reg.first_only   <= 1'b0;
        end
        else
            cfg_reg <= cfg_next;
    end

    dtph_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .init_busy  (init_busy),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_push     (q_push),
        .q_data     (q_wdata),
        .q_full     (q_full)
    );

    dtph_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_valid)
    );

    dtph_back #(
        .MAX_BINS (MAX_BINS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .init_busy    (init_busy),
        .q_valid      (q_valid),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// File: src/dtph_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtph_front - item intake and dead-time classification
// Tracks cycle base, dead-time window and per-cycle detection; issues
// commands into the queue.
// ----------------------------------------------------------------------------
module dtph_front #(
    parameter int unsigned TIME_BITS = 24
) (
    input  logic           clk,
    input  logic           rst_n,
    input  dtph_pkg::cfg_t cfg,
    input  logic           init_busy,
    input  logic           item_valid,
    output logic           item_ready,
    input  dtph_pkg::item_t item,
    output logic           q_push,
    output dtph_pkg::cmd_t q_data,
    input  logic           q_full
);
    import dtph_pkg::*;

    localparam logic [TW-1:0] T_MASK = TW'((65'd1 << TIME_BITS) - 65'd1);

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_CALC  = 3'b010,
        F_ISSUE = 3'b100
    } fstate_t;

    fstate_t        state_reg, state_next;
    logic [1:0]     act_reg, act_next;
    logic [TW-1:0]  t_reg, t_next;
    logic [RBW-1:0] rb_reg, rb_next;
    logic [AW-1:0]  abs_reg, abs_next;
    logic           late_reg, late_next;
    logic [AW-1:0]  base_reg, base_next;
    logic [AW-1:0]  ready_time_reg, ready_time_next;
    logic           det_reg, det_next;

    logic [TW-1:0]  period;
    logic [AW-1:0]  abs_plus_dt;
    logic           lost;

    assign period      = cfg.cycle_period & T_MASK;
    assign abs_plus_dt = abs_reg + AW'(cfg.blind_ticks);
    assign lost        = (cfg.blind_ticks != '0) && (abs_reg < ready_time_reg);
    assign item_ready  = (state_reg == F_IDLE) && !init_busy;

    // sequencing and classification
    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        t_next          = t_reg;
        rb_next         = rb_reg;
        abs_next        = abs_reg;
        late_next       = late_reg;
        base_next       = base_reg;
        ready_time_next = ready_time_reg;
        det_next        = det_reg;
        q_push          = 1'b0;
        q_data.kind     = CMD_NOP;
        q_data.t        = t_reg;
        q_data.rb       = rb_reg;
        q_data.inc_hit  = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (item_valid && item_ready)
                begin
                    act_next   = item.action;
                    t_next     = item.event_time & T_MASK;
                    rb_next    = item.read_bin;
                    state_next = F_CALC;
                end
            end
            F_CALC:
            begin
                abs_next   = base_reg + AW'(t_reg);
                late_next  = (t_reg >= period);
                state_next = F_ISSUE;
            end
            F_ISSUE:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                    case (act_reg)
                        ACT_PHOTON:
                        begin
                            if (!late_reg)
                            begin
                                if (lost)
                                begin
                                    if (cfg.paralyzable)
                                        ready_time_next = abs_plus_dt;
                                end
                                else
                                begin
                                    ready_time_next = abs_plus_dt;
                                    if (!cfg.first_only || !det_reg)
                                    begin
                                        q_data.kind    = CMD_BIN;
                                        q_data.inc_hit = !det_reg;
                                        det_next       = 1'b1;
                                    end
                                end
                            end
                        end
                        ACT_NEXT:
                        begin
                            base_next = base_reg + AW'(period);
                            det_next  = 1'b0;
                        end
                        ACT_READ:  q_data.kind = CMD_READ;
                        ACT_CLEAR: q_data.kind = CMD_CLEAR;
                        default:   q_data.kind = CMD_NOP;
                    endcase
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            base_reg       <= '0;
            ready_time_reg <= '0;
            det_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            ready_time_reg <= ready_time_next;
            det_reg        <= det_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        t_reg    <= t_next;
        rb_reg   <= rb_next;
        abs_reg  <= abs_next;
        late_reg <= late_next;
    end

endmodule

// File: src/dtph_cmdq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtph_cmdq - two-entry command queue
// Decouples the classification front from the histogram back end.
// ----------------------------------------------------------------------------
module dtph_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dtph_pkg::cmd_t wdata,
    output logic           full,
    input  logic           pop,
    output dtph_pkg::cmd_t rdata,
    output logic           not_empty
);
    import dtph_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign rdata     = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// File: src/dtph_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtph_back - bin divider, histogram memory and result register
// Restoring divider for the bin index, read-modify-write of the saturating
// histogram, clearing sweep, and the output register.
// ----------------------------------------------------------------------------
module dtph_back #(
    parameter int unsigned MAX_BINS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dtph_pkg::cfg_t   cfg,
    output logic             init_busy,
    input  logic             q_valid,
    input  dtph_pkg::cmd_t   q_data,
    output logic             q_pop,
    output logic             result_valid,
    input  logic             result_ready,
    output dtph_pkg::result_t result
);
    import dtph_pkg::*;

    localparam int unsigned BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(MAX_BINS - 1);
    localparam logic [4:0] LAST_STEP = 5'(TW - 1);

    typedef enum logic [5:0] {
        B_INIT = 6'b000001,
        B_IDLE = 6'b000010,
        B_DIV  = 6'b000100,
        B_RD   = 6'b001000,
        B_UPD  = 6'b010000,
        B_CLR  = 6'b100000
    } bstate_t;

    bstate_t        state_reg, state_next;
    logic [BWW-1:0] rem_reg, rem_next;
    logic [TW-1:0]  quot_reg, quot_next;
    logic [4:0]     step_reg, step_next;
    logic [BIN_W-1:0] addr_reg, addr_next;
    logic           is_read_reg, is_read_next;
    logic           inc_reg, inc_next;
    logic [CW-1:0]  hit_reg, hit_next;
    logic           out_valid_reg, out_valid_next;
    result_t        res_reg, res_next;
    logic [CW-1:0]  rd_data_reg;

    logic [CW-1:0]  hist_mem [MAX_BINS];
    logic           mem_we;
    logic [BIN_W-1:0] mem_waddr;
    logic [CW-1:0]  mem_wdata;

    logic [BWW-1:0] w_eff;
    logic [BWW:0]   shifted;
    logic [BWW+1:0] diff;
    logic [TW-1:0]  quot_fin;
    logic [31:0]    lim;
    logic           in_range;
    logic           slot_free;
    logic [CW-1:0]  hit_upd;

    assign w_eff     = (cfg.bin_ticks == '0) ? BWW'(1) : cfg.bin_ticks;
    assign shifted   = {rem_reg, quot_reg[TW-1]};
    assign diff      = {1'b0, shifted} - {2'b00, w_eff};
    assign quot_fin  = {quot_reg[TW-2:0], ~diff[BWW+1]};
    assign lim       = (32'(cfg.bins_in_use) > 32'(MAX_BINS)) ? 32'(MAX_BINS)
                                                              : 32'(cfg.bins_in_use);
    assign in_range  = 32'(quot_fin) < lim;
    assign slot_free = !out_valid_reg || result_ready;
    assign hit_upd   = inc_reg ? sat_inc(hit_reg) : hit_reg;
    assign init_busy = (state_reg == B_INIT);

    assign result_valid = out_valid_reg;
    assign result       = res_reg;

    // control
    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        step_next      = step_reg;
        addr_next      = addr_reg;
        is_read_next   = is_read_reg;
        inc_next       = inc_reg;
        hit_next       = hit_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !result_ready;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = '0;
        case (state_reg)
            B_INIT, B_CLR:
            begin
                // sweep one bin per cycle
                mem_we    = 1'b1;
                addr_next = addr_reg + BIN_W'(1);
                if (addr_reg == LAST_BIN)
                begin
                    addr_next  = '0;
                    state_next = B_IDLE;
                    if (state_reg == B_CLR)
                    begin
                        res_next       = '0;
                        out_valid_next = 1'b1;
                    end
                end
            end
            B_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop                    = 1'b1;
                    res_next                 = '0;
                    res_next.recorded_cycles = hit_reg;
                    case (q_data.kind)
                        CMD_BIN:
                        begin
                            rem_next   = '0;
                            quot_next  = q_data.t;
                            step_next  = '0;
                            inc_next   = q_data.inc_hit;
                            state_next = B_DIV;
                        end
                        CMD_READ:
                        begin
                            if (32'(q_data.rb) < 32'(MAX_BINS))
                            begin
                                addr_next    = BIN_W'(q_data.rb);
                                is_read_next = 1'b1;
                                state_next   = B_RD;
                            end
                            else
                                out_valid_next = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            hit_next   = '0;
                            addr_next  = '0;
                            state_next = B_CLR;
                        end
                        default: out_valid_next = 1'b1;
                    endcase
                end
            end
            B_DIV:
            begin
                // one quotient bit per cycle
                rem_next  = diff[BWW+1] ? shifted[BWW-1:0] : diff[BWW-1:0];
                quot_next = quot_fin;
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_STEP)
                begin
                    hit_next                 = hit_upd;
                    res_next.recorded_cycles = hit_upd;
                    if (in_range)
                    begin
                        addr_next    = BIN_W'(quot_fin);
                        is_read_next = 1'b0;
                        state_next   = B_RD;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        state_next     = B_IDLE;
                    end
                end
            end
            B_RD: state_next = B_UPD;
            B_UPD:
            begin
                out_valid_next = 1'b1;
                state_next     = B_IDLE;
                if (is_read_reg)
                    res_next.bin_count = rd_data_reg;
                else
                begin
                    mem_we           = 1'b1;
                    mem_wdata        = sat_inc(rd_data_reg);
                    res_next.accepted = 1'b1;
                    res_next.bin_hit  = RBW'(32'(addr_reg));
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            addr_reg      <= '0;
            hit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        step_reg    <= step_next;
        is_read_reg <= is_read_next;
        inc_reg     <= inc_next;
        res_reg     <= res_next;
    end

    // histogram memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= hist_mem[addr_reg];
    end

    // the read-modify-write always follows its read cycle
    a_upd_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_UPD |-> $past(state_reg) == B_RD)
        else $error("update without preceding read");

    // a command is taken only when the result slot can hold its result
    a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!out_valid_reg || result_ready))
        else $error("command popped with result slot busy");

    // no result is produced during the reset sweep
    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_INIT |=> !$rose(out_valid_reg))
        else $error("result during reset sweep");

endmodule
